// ----- rtl/core/tss_pkg.sv -----
package tss_pkg;

    localparam int CMD_W       = 2;
    localparam int IDX_W       = 5;
    localparam int DVAL_W      = 16;
    localparam int NEXT_W      = 6;
    localparam int CNT_W       = 6;
    localparam int MAX_RESULTS = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_JUMP    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_LOAD    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRE,
        S_LOAD,
        S_OUT
    } t_state;

endpackage

// ----- rtl/core/tss_if.sv -----
interface tss_in_if;
    logic                         valid;
    logic                         ready;
    logic [tss_pkg::CMD_W-1:0]    cmd;
    logic [tss_pkg::IDX_W-1:0]    step_index;
    logic [tss_pkg::DVAL_W-1:0]   delay_value;
    logic [tss_pkg::IDX_W-1:0]    query_step;

    modport source (output valid, cmd, step_index, delay_value, query_step, input ready);
    modport sink   (input valid, cmd, step_index, delay_value, query_step, output ready);
endinterface

interface tss_out_if;
    logic                         valid;
    logic                         ready;
    logic                         fired;
    logic [tss_pkg::IDX_W-1:0]    fired_step;
    logic                         last;
    logic                         finished;
    logic [tss_pkg::NEXT_W-1:0]   next_step;
    logic                         step_done;
    logic                         bad_jump;

    modport source (output valid, fired, fired_step, last, finished, next_step, step_done,
                    bad_jump, input ready);
    modport sink   (input valid, fired, fired_step, last, finished, next_step, step_done,
                    bad_jump, output ready);
endinterface

interface tss_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tss_pkg::CNT_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/tss_delay_mem.sv -----
module tss_delay_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/timed_step_sequencer.sv -----
// Frame-ticked step sequencer over a delay table held in a one-write, one-read RAM with
// registered read data. One word is taken at a time; ready is low until its last result
// word is taken. A tick goes from S_FIRE through an S_LOAD table read for each step that
// fires and back to S_FIRE, using the single countdown/index unit; S_OUT then gives one
// result word per fired step (one result when nothing fires). Restart goes through S_LOAD
// to S_OUT, jump and table load straight to S_OUT. The config port is always ready and must
// only be written while no word is in flight. Steps fired per tick are capped at 32.
module timed_step_sequencer #(
    parameter int MAX_STEPS  = 32,
    parameter int DELAY_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tss_in_if.sink        i_item,
    tss_out_if.source     o_result,
    tss_cfg_if.sink       i_cfg
);

    import tss_pkg::*;

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int DW = DELAY_BITS;
    localparam int RW = $clog2(MAX_RESULTS + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_step_count;
    logic [NEXT_W-1:0]   r_next, n_next;
    logic [DW-1:0]       r_frames, n_frames;
    t_cmd                r_cmd, n_cmd;
    logic [IDX_W-1:0]    r_query, n_query;
    logic                r_bad, n_bad;
    logic [NEXT_W-1:0]   r_start, n_start;
    logic [RW-1:0]       r_n, n_n;
    logic [RW-1:0]       r_k, n_k;

    logic [CNT_W-1:0]    cnt;
    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [DW-1:0]       mem_rdata;
    logic                fire_ok;
    logic                frames_zero;
    logic                is_last;
    logic [NEXT_W-1:0]   fired_sum;

    // Count above the table size behaves as the table size.
    assign cnt = (32'(r_step_count) > MAX_STEPS) ? CNT_W'(MAX_STEPS) : r_step_count;

    assign frames_zero = (r_frames == '0);
    assign fire_ok     = frames_zero && (r_next < cnt) && (32'(r_n) < MAX_RESULTS);

    assign mem_we    = (r_state == S_IDLE) && i_item.valid
                       && (t_cmd'(i_item.cmd) == CMD_LOAD)
                       && (32'(i_item.step_index) < MAX_STEPS);
    assign mem_raddr = (r_state == S_FIRE) ? AW'(r_next + NEXT_W'(1)) : '0;

    tss_delay_mem #(
        .DEPTH (MAX_STEPS),
        .WIDTH (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_item.step_index)),
        .i_wdata (DW'(i_item.delay_value)),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= '0;
        end else if (i_cfg.valid) begin
            r_step_count <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_next   <= '0;
            r_frames <= '0;
            r_n      <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_next   <= n_next;
            r_frames <= n_frames;
            r_n      <= n_n;
            r_k      <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_query <= n_query;
        r_bad   <= n_bad;
        r_start <= n_start;
    end

    assign is_last = (r_n == '0) || (r_k == r_n - RW'(1));

    always_comb begin
        n_state  = r_state;
        n_next   = r_next;
        n_frames = r_frames;
        n_cmd    = r_cmd;
        n_query  = r_query;
        n_bad    = r_bad;
        n_start  = r_start;
        n_n      = r_n;
        n_k      = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_cmd   = t_cmd'(i_item.cmd);
                    n_query = i_item.query_step;
                    n_bad   = 1'b0;
                    n_start = r_next;
                    n_n     = '0;
                    n_k     = '0;
                    case (t_cmd'(i_item.cmd))
                        CMD_TICK: begin
                            n_state = S_FIRE;
                        end
                        CMD_JUMP: begin
                            if (NEXT_W'(i_item.step_index) < cnt) begin
                                n_next   = NEXT_W'(i_item.step_index);
                                n_frames = DW'(i_item.delay_value);
                            end else begin
                                n_bad = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        CMD_RESTART: begin
                            n_next  = '0;
                            n_state = S_LOAD;
                        end
                        CMD_LOAD: begin
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_FIRE: begin
                if (fire_ok) begin
                    n_next  = r_next + NEXT_W'(1);
                    n_n     = r_n + RW'(1);
                    n_state = S_LOAD;
                end else begin
                    // Countdown holds when finished or when the cap cut a zero-delay chain.
                    if ((r_next != cnt)
                        && !(frames_zero && (32'(r_n) == MAX_RESULTS) && (r_next < cnt))) begin
                        n_frames = r_frames - DW'(1);
                    end
                    n_state = S_OUT;
                end
            end
            S_LOAD: begin
                // Read data is for the step now at r_next.
                if (r_next < cnt) begin
                    n_frames = mem_rdata;
                end else if (r_cmd == CMD_RESTART) begin
                    n_frames = '0;
                end
                n_state = (r_cmd == CMD_TICK) ? S_FIRE : S_OUT;
            end
            S_OUT: begin
                if (o_result.ready) begin
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + RW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign fired_sum = r_start + NEXT_W'(r_k);

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_result.valid      = (r_state == S_OUT);
    assign o_result.fired      = (r_n != '0);
    assign o_result.fired_step = (r_n != '0) ? fired_sum[IDX_W-1:0] : '0;
    assign o_result.last       = is_last;
    assign o_result.finished   = (r_next == cnt);
    assign o_result.next_step  = r_next;
    assign o_result.step_done  = (r_next > NEXT_W'(r_query));
    assign o_result.bad_jump   = r_bad;

endmodule

// ----- rtl/core/tss_checker.sv -----
module tss_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_fired,
    input logic [tss_pkg::IDX_W-1:0]     i_out_fired_step,
    input logic                          i_out_last,
    input logic                          i_out_bad_jump
);

    import tss_pkg::*;

    // one word in flight: no new word while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after accept");

    // fired steps come out back to back with consecutive indexes
    a_fire_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && i_out_fired
             && (i_out_fired_step == $past(i_out_fired_step) + IDX_W'(1))))
        else $error("fired step sequence broken");

    a_single_nonfire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (!i_out_fired || i_out_bad_jump)) |-> i_out_last)
        else $error("non-fired result not marked last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_fired_step)))
        else $error("stalled result changed");

endmodule

bind timed_step_sequencer tss_checker u_tss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_out_fired      (o_result.fired),
    .i_out_fired_step (o_result.fired_step),
    .i_out_last       (o_result.last),
    .i_out_bad_jump   (o_result.bad_jump)
);
